// ===== rtl/core/ilm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ilm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TOTAL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEVEL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_PERIODS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_PERIODS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_PERIODS      = 3'd6;

	localparam int TICK_W = 20;
	localparam int WIN_W  = 21;

	localparam logic [12:0] PERIOD_MAX = 13'd4096;

	localparam logic [12:0] RST_PERIOD_LENGTH    = 13'd128;
	localparam logic [4:0]  RST_PULSE_TOTAL      = 5'd5;
	localparam logic [31:0] RST_DETECT_THRESHOLD = 32'd429496730;
	localparam logic [30:0] RST_PULSE_LEVEL      = 31'd1717986944;
	localparam logic [7:0]  RST_FLUSH_PERIODS    = 8'd20;
	localparam logic [7:0]  RST_TIMEOUT_PERIODS  = 8'd100;
	localparam logic [7:0]  RST_GAP_PERIODS      = 8'd10;

	typedef struct packed {
		logic [12:0] period_length;
		logic [4:0]  pulse_total;
		logic [31:0] detect_threshold;
		logic [30:0] pulse_level;
		logic [7:0]  flush_periods;
		logic [7:0]  timeout_periods;
		logic [7:0]  gap_periods;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic hit;
	} item_t;

	typedef struct packed {
		logic signed [31:0] play_sample;
		logic               busy;
		logic               done;
		logic               success;
		logic [TICK_W-1:0]  latency;
	} res_t;

	typedef struct packed {
		logic              wr_en;
		logic              start;
		logic [TICK_W-1:0] wr_data;
	} med_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/ilm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ilm_front import ilm_pkg::*; (
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               cmd,
	input  wire logic signed [31:0] capture_sample,
	input  wire logic [31:0]        threshold,
	input  wire logic               q_full,
	output logic                    push,
	output item_t                   push_item
);

	logic [31:0] raw;
	logic [31:0] mag;

	assign raw = capture_sample;
	// most negative sample gives 2^31 in unsigned form
	assign mag = raw[31] ? (32'd0 - raw) : raw;

	assign in_ready        = !q_full;
	assign push            = in_valid && !q_full;
	assign push_item.start = cmd;
	assign push_item.hit   = (mag >= threshold);

endmodule

`default_nettype wire

// ===== rtl/core/ilm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ilm_queue import ilm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  item_t     push_item,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output item_t     head
);

	item_t      slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ilm_median.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ilm_median import ilm_pkg::*; #(
	parameter int MAX_PULSES = 16,
	localparam int AW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1,
	localparam int CW = $clog2(MAX_PULSES + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  med_req_t               req,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [CW-1:0]     n,
	output logic                   done,
	output logic [TICK_W-1:0]      result
);

	logic [TICK_W-1:0] mem [MAX_PULSES];

	logic              run_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     lo_idx_q;
	logic [CW-1:0]     hi_idx_q;
	logic              odd_q;
	logic [CW-1:0]     acc_q;
	logic              fin_q;
	logic              done_q;
	logic [TICK_W-1:0] lo_q;
	logic [TICK_W-1:0] hi_q;
	logic [TICK_W-1:0] result_q;

	logic              v_s1;
	logic              jlast_s1;
	logic              ilast_s1;
	logic [AW-1:0]     i_s1;
	logic [AW-1:0]     j_s1;
	logic [TICK_W-1:0] rd_a_s1;
	logic [TICK_W-1:0] rd_b_s1;

	logic              jlast;
	logic              ilast;
	logic              lt;
	logic [CW-1:0]     rank;
	logic [CW-1:0]     mid;
	logic [TICK_W:0]   sum;

	assign jlast = (CW'(j_q) == n_q - CW'(1));
	assign ilast = (CW'(i_q) == n_q - CW'(1));
	// stable rank: ties ordered by store position
	assign lt    = (rd_b_s1 < rd_a_s1) || ((rd_b_s1 == rd_a_s1) && (j_s1 < i_s1));
	assign rank  = acc_q + CW'(lt);
	assign mid   = n >> 1;
	assign sum   = {1'b0, lo_q} + {1'b0, hi_q};

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_addr] <= req.wr_data;
		end
		rd_a_s1 <= mem[i_q];
		rd_b_s1 <= mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			n_q      <= '0;
			lo_idx_q <= '0;
			hi_idx_q <= '0;
			odd_q    <= 1'b0;
			acc_q    <= '0;
			fin_q    <= 1'b0;
			done_q   <= 1'b0;
			v_s1     <= 1'b0;
			jlast_s1 <= 1'b0;
			ilast_s1 <= 1'b0;
			i_s1     <= '0;
			j_s1     <= '0;
		end else begin
			v_s1     <= run_q;
			jlast_s1 <= jlast;
			ilast_s1 <= jlast && ilast;
			i_s1     <= i_q;
			j_s1     <= j_q;
			fin_q    <= v_s1 && ilast_s1;
			done_q   <= fin_q;
			if (req.start) begin
				run_q    <= 1'b1;
				i_q      <= '0;
				j_q      <= '0;
				n_q      <= n;
				odd_q    <= n[0];
				hi_idx_q <= mid;
				lo_idx_q <= n[0] ? mid : (mid - CW'(1));
				acc_q    <= '0;
			end else if (run_q) begin
				if (jlast) begin
					j_q <= '0;
					if (ilast) begin
						run_q <= 1'b0;
					end else begin
						i_q <= i_q + AW'(1);
					end
				end else begin
					j_q <= j_q + AW'(1);
				end
			end
			if (v_s1) begin
				acc_q <= jlast_s1 ? '0 : rank;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && jlast_s1) begin
			if (rank == lo_idx_q) begin
				lo_q <= rd_a_s1;
			end
			if (rank == hi_idx_q) begin
				hi_q <= rd_a_s1;
			end
		end
		if (fin_q) begin
			result_q <= odd_q ? hi_q : sum[TICK_W:1];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ilm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ilm_back import ilm_pkg::*; #(
	parameter int MAX_PULSES = 16,
	localparam int AW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1,
	localparam int CW = $clog2(MAX_PULSES + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cfg_t                   cfg,
	input  wire logic              empty,
	input  item_t                  head,
	output logic                   pop,
	output med_req_t               med_req,
	output logic [AW-1:0]          med_addr,
	output logic [CW-1:0]          med_n,
	input  wire logic              med_done,
	input  wire logic [TICK_W-1:0] med_result,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output res_t                   out_res
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FLUSH  = 2'd1;
	localparam logic [1:0] PH_LISTEN = 2'd2;
	localparam logic [1:0] PH_GAP    = 2'd3;

	logic [1:0]        phase_q;
	logic [TICK_W-1:0] tick_q;
	logic [CW-1:0]     pm_q;
	logic              med_wait_q;
	logic              out_valid_q;
	res_t              out_res_q;

	logic [12:0]       eff_period;
	logic [CW-1:0]     eff_total;
	logic [WIN_W-1:0]  win_flush;
	logic [WIN_W-1:0]  win_gap;
	logic [WIN_W-1:0]  win_to;
	logic [WIN_W-1:0]  tmo;
	logic [WIN_W-1:0]  tick_inc;

	logic [1:0]        nxt_phase;
	logic [TICK_W-1:0] nxt_tick;
	logic [CW-1:0]     nxt_pm;
	logic              go_after;
	logic              fin_ok;
	res_t              res;

	always_comb begin
		if (cfg.period_length == 13'd0) begin
			eff_period = 13'd1;
		end else if (cfg.period_length > PERIOD_MAX) begin
			eff_period = PERIOD_MAX;
		end else begin
			eff_period = cfg.period_length;
		end
		if (cfg.pulse_total == 5'd0) begin
			eff_total = CW'(1);
		end else if (32'(cfg.pulse_total) > MAX_PULSES) begin
			eff_total = CW'(MAX_PULSES);
		end else begin
			eff_total = CW'(cfg.pulse_total);
		end
	end

	assign win_flush = WIN_W'(cfg.flush_periods) * WIN_W'(eff_period);
	assign win_gap   = WIN_W'(cfg.gap_periods) * WIN_W'(eff_period);
	assign win_to    = WIN_W'(cfg.timeout_periods) * WIN_W'(eff_period);
	assign tmo       = (win_to == '0) ? WIN_W'(eff_period) : win_to;
	assign tick_inc  = WIN_W'(tick_q) + WIN_W'(1);

	always_comb begin
		nxt_phase       = phase_q;
		nxt_tick        = tick_q;
		nxt_pm          = pm_q;
		go_after        = 1'b0;
		fin_ok          = 1'b0;
		res             = '0;
		med_req.wr_en   = 1'b0;
		med_req.wr_data = tick_q;
		if (head.start) begin
			if (phase_q == PH_IDLE) begin
				nxt_pm    = '0;
				nxt_tick  = '0;
				nxt_phase = (win_flush == '0) ? PH_LISTEN : PH_FLUSH;
			end
		end else begin
			unique case (phase_q)
				PH_FLUSH: begin
					if (tick_inc >= win_flush) begin
						nxt_tick  = '0;
						nxt_phase = PH_LISTEN;
					end else begin
						nxt_tick = tick_inc[TICK_W-1:0];
					end
				end
				PH_LISTEN: begin
					if (tick_q == '0) begin
						res.play_sample = {1'b0, cfg.pulse_level};
					end
					if (head.hit) begin
						med_req.wr_en = 1'b1;
						nxt_pm        = pm_q + CW'(1);
						nxt_tick      = '0;
						if (win_gap == '0) begin
							go_after = 1'b1;
						end else begin
							nxt_phase = PH_GAP;
						end
					end else if (tick_inc >= tmo) begin
						nxt_phase = PH_IDLE;
						nxt_tick  = '0;
						res.done  = 1'b1;
					end else begin
						nxt_tick = tick_inc[TICK_W-1:0];
					end
				end
				PH_GAP: begin
					if (tick_inc >= win_gap) begin
						go_after = 1'b1;
					end else begin
						nxt_tick = tick_inc[TICK_W-1:0];
					end
				end
				default: begin
					nxt_phase = PH_IDLE;
				end
			endcase
		end
		if (go_after) begin
			nxt_tick = '0;
			if (nxt_pm >= eff_total) begin
				fin_ok      = 1'b1;
				nxt_phase   = PH_IDLE;
				res.done    = 1'b1;
				res.success = 1'b1;
			end else begin
				nxt_phase = (win_flush == '0) ? PH_LISTEN : PH_FLUSH;
			end
		end
		res.busy = (nxt_phase != PH_IDLE);
	end

	assign pop           = !empty && !med_wait_q && (!out_valid_q || out_ready);
	assign med_req.start = pop && fin_ok;
	assign med_addr      = pm_q[AW-1:0];
	assign med_n         = nxt_pm;
	assign out_valid     = out_valid_q;
	assign out_res       = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			pm_q        <= '0;
			med_wait_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= nxt_phase;
				tick_q      <= nxt_tick;
				pm_q        <= nxt_pm;
				med_wait_q  <= fin_ok;
				out_valid_q <= !fin_ok;
			end else if (med_done) begin
				med_wait_q  <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= res;
		end else if (med_done) begin
			out_res_q.latency <= med_result;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/impulse_loopback_latency_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: an accepted transaction is queued, and its result is registered on pop
// throughput: one sample tick per cycle while neither the output nor a pending
// median stalls, set by the phase update; the tick that completes a successful
// run waits for the median from a one-compare-per-cycle rank scan of the store
// reset: control, phase and counters clear, registers take their defaults,
// the latency store is not cleared

module impulse_loopback_latency_meter import ilm_pkg::*; #(
	parameter int MAX_PULSES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  cmd,
	input  wire logic signed [31:0]    capture_sample,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [31:0]         play_sample,
	output logic                       busy_res,
	output logic                       done_res,
	output logic                       success,
	output logic [TICK_W-1:0]          latency,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
	localparam int CW = $clog2(MAX_PULSES + 1);

	cfg_t              cfg_q;
	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	item_t             push_item;
	item_t             head;
	med_req_t          med_req;
	logic [AW-1:0]     med_addr;
	logic [CW-1:0]     med_n;
	logic              med_done;
	logic [TICK_W-1:0] med_result;
	res_t              out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_length    <= RST_PERIOD_LENGTH;
			cfg_q.pulse_total      <= RST_PULSE_TOTAL;
			cfg_q.detect_threshold <= RST_DETECT_THRESHOLD;
			cfg_q.pulse_level      <= RST_PULSE_LEVEL;
			cfg_q.flush_periods    <= RST_FLUSH_PERIODS;
			cfg_q.timeout_periods  <= RST_TIMEOUT_PERIODS;
			cfg_q.gap_periods      <= RST_GAP_PERIODS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PERIOD_LENGTH:    cfg_q.period_length    <= cfg_data[12:0];
				CFG_PULSE_TOTAL:      cfg_q.pulse_total      <= cfg_data[4:0];
				CFG_DETECT_THRESHOLD: cfg_q.detect_threshold <= cfg_data;
				CFG_PULSE_LEVEL:      cfg_q.pulse_level      <= cfg_data[30:0];
				CFG_FLUSH_PERIODS:    cfg_q.flush_periods    <= cfg_data[7:0];
				CFG_TIMEOUT_PERIODS:  cfg_q.timeout_periods  <= cfg_data[7:0];
				CFG_GAP_PERIODS:      cfg_q.gap_periods      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	ilm_front u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.capture_sample (capture_sample),
		.threshold      (cfg_q.detect_threshold),
		.q_full         (q_full),
		.push           (push),
		.push_item      (push_item)
	);

	ilm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	ilm_median #(.MAX_PULSES(MAX_PULSES)) u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (med_req),
		.wr_addr (med_addr),
		.n       (med_n),
		.done    (med_done),
		.result  (med_result)
	);

	ilm_back #(.MAX_PULSES(MAX_PULSES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.empty      (q_empty),
		.head       (head),
		.pop        (pop),
		.med_req    (med_req),
		.med_addr   (med_addr),
		.med_n      (med_n),
		.med_done   (med_done),
		.med_result (med_result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res)
	);

	assign play_sample = out_res.play_sample;
	assign busy_res    = out_res.busy;
	assign done_res    = out_res.done;
	assign success     = out_res.success;
	assign latency     = out_res.latency;

endmodule

`default_nettype wire

// ===== rtl/core/ilm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ilm_checker import ilm_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  cmd,
	input wire logic signed [31:0]    capture_sample,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic signed [31:0]    play_sample,
	input wire logic                  busy_res,
	input wire logic                  done_res,
	input wire logic                  success,
	input wire logic [TICK_W-1:0]     latency,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [2:0] pend_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// transactions accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_fire && !out_fire) begin
			pend_q <= pend_q + 3'd1;
		end else if (out_fire && !in_fire) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(play_sample) && $stable(latency)
			&& $stable(done_res) && $stable(success) && $stable(busy_res))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without an accepted transaction");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("finished run still busy");

	a_quiet_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(done_res && success) |-> latency == '0 && !(success && !done_res))
		else $error("latency or success outside a successful finish");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && cmd && in_valid && pend_q == 3'd1 && $past(in_fire && cmd) |-> busy_res)
		else $error("start transaction reported idle");

endmodule

bind impulse_loopback_latency_meter ilm_checker u_ilm_checker (.*);

`default_nettype wire
